@@ src/decimal_accumulator_machine_step_macros.svh @@
// ----------------------------------------------------------------------------
// Decimal accumulator machine assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ACCUMULATOR_MACHINE_STEP_MACROS_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_STEP_MACROS_SVH

// same-cycle implication
`define DAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dam check failed");

// next-cycle implication
`define DAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dam check failed");

`endif

@@ src/dam_pkg.sv @@
// ----------------------------------------------------------------------------
// dam_pkg
// Shared constants, codes and types of the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

    localparam int unsigned MEM_DEPTH_DEF = 128;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [6:0] OP_LOAD  = 7'd11;
    localparam logic [6:0] OP_STORE = 7'd12;
    localparam logic [6:0] OP_ADD   = 7'd21;
    localparam logic [6:0] OP_SUB   = 7'd22;
    localparam logic [6:0] OP_MUL   = 7'd23;
    localparam logic [6:0] OP_DIV   = 7'd24;
    localparam logic [6:0] OP_REM   = 7'd25;
    localparam logic [6:0] OP_READ  = 7'd31;
    localparam logic [6:0] OP_PRINT = 7'd41;
    localparam logic [6:0] OP_NOP   = 7'd50;
    localparam logic [6:0] OP_BR    = 7'd51;
    localparam logic [6:0] OP_BRGT  = 7'd52;
    localparam logic [6:0] OP_BRGE  = 7'd53;
    localparam logic [6:0] OP_BRLT  = 7'd54;
    localparam logic [6:0] OP_BRLE  = 7'd55;
    localparam logic [6:0] OP_BRNE  = 7'd56;
    localparam logic [6:0] OP_BREQ  = 7'd57;
    localparam logic [6:0] OP_SHL   = 7'd61;
    localparam logic [6:0] OP_SHR   = 7'd62;
    localparam logic [6:0] OP_HALT  = 7'd70;

    // word / 100 for words below 8192: (w * 5243) >> 19
    localparam logic [12:0] DEC_BASE    = 13'd100;
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam logic [31:0] SHL_MOD     = 32'd100000;
    localparam logic [31:0] SHR_DIV     = 32'd10;

    // magnitudes up to 2**31: n / 10 = (n * SHR_RECIP) >> 35,
    // n / 100000 = (n * SHL_RECIP) >> 48
    localparam logic [31:0] SHR_RECIP   = 32'd3435973837;
    localparam logic [31:0] SHL_RECIP   = 32'd2814749768;
    localparam int unsigned SHR_SHIFT   = 35;
    localparam int unsigned SHL_SHIFT   = 48;

    typedef struct packed {
        logic        start;
        logic        fast;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

@@ src/dam_mem.sv @@
// ----------------------------------------------------------------------------
// dam_mem
// Single-port word memory, registered read data.
// ----------------------------------------------------------------------------
module dam_mem #(
    parameter int unsigned DEPTH = dam_pkg::MEM_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ src/dam_div.sv @@
// ----------------------------------------------------------------------------
// dam_div
// Iterative signed divider, one quotient bit per cycle, truncating. With fast
// set, a reciprocal-multiply path divides by ten (divisor 10), else by 100000.
// ----------------------------------------------------------------------------
module dam_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dam_pkg::div_req_t req,
    output dam_pkg::div_rsp_t rsp
);
    import dam_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [2:0]  stg_reg, stg_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [63:0] prod_reg, prod_next;
    logic        ten_reg, ten_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        stg_next  = {stg_reg[1:0], 1'b0};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        prod_next = prod_reg;
        ten_next  = ten_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (req.start)
        begin
            busy_next = !req.fast;
            stg_next  = {2'b00, req.fast};
            ten_next  = (req.divisor == SHR_DIV);
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            dvs_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            qneg_next = req.dividend[31] ^ req.divisor[31];
            rneg_next = req.dividend[31];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (stg_reg[0])
        begin
            prod_next = 64'(quo_reg) * 64'(ten_reg ? SHR_RECIP : SHL_RECIP);
        end
        else if (stg_reg[1])
        begin
            rem_next = quo_reg;
            quo_next = ten_reg ? 32'(prod_reg >> SHR_SHIFT) : 32'(prod_reg >> SHL_SHIFT);
        end
        else if (stg_reg[2])
        begin
            rem_next  = ten_reg ? (rem_reg - quo_reg * SHR_DIV)
                                : (rem_reg - quo_reg * SHL_MOD);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            stg_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            stg_reg  <= stg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        prod_reg <= prod_next;
        ten_reg  <= ten_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign rsp.rem  = rneg_reg ? (32'd0 - rem_reg) : rem_reg;

endmodule

@@ src/decimal_accumulator_machine_step.sv @@
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_step
// Decimal accumulator machine: memory write, single-step execute, restart.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | cmd, mem_addr, mem_word, in_value
//  result  | res_valid / res_stall| run_status, out_valid, out_value,
//          |                      | in_used, acc_now, pc_now
//
//  Write, restart and stopped execute go from idle straight to done. Execute
//  steps through fetch, decode and, for operand ops, an operand read on the
//  one memory port; divide and remainder by a nonzero operand then wait on
//  the bit-serial divider, decimal shifts on its reciprocal path.
//  After reset a clearing pass zeroes every memory word with in_stall high.
//  One item in flight; the result register lets the next item enter
//  while a result waits under res_stall.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_step #(
    parameter int unsigned MEM_DEPTH = dam_pkg::MEM_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [6:0]         mem_addr,
    input  logic signed [31:0] mem_word,
    input  logic signed [31:0] in_value,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         run_status,
    output logic               out_valid,
    output logic signed [31:0] out_value,
    output logic               in_used,
    output logic signed [31:0] acc_now,
    output logic [6:0]         pc_now
);
    import dam_pkg::*;

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_DECODE = 7'b0001000,
        S_OPER   = 7'b0010000,
        S_DIVW   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      pc_reg, pc_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [1:0]         stat_reg, stat_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [31:0]        inv_reg, inv_next;
    logic [12:0]        w13_reg, w13_next;
    logic [6:0]         opc_reg, opc_next;
    logic               bad_reg, bad_next;
    logic               prt_reg, prt_next;
    logic [31:0]        prtv_reg, prtv_next;
    logic               used_reg, used_next;

    logic               res_valid_reg, res_valid_next;
    logic [1:0]         r_stat_reg;
    logic               r_prt_reg;
    logic [31:0]        r_prtv_reg;
    logic               r_used_reg;
    logic [31:0]        r_acc_reg;
    logic [6:0]         r_pc_reg;
    logic               res_load;

    logic               mem_en, mem_we;
    logic [AW-1:0]      mem_a;
    logic [31:0]        mem_wd, mem_rd;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [AW-1:0]      pc_inc;
    logic [25:0]        recip_prod;
    logic [12:0]        hund;
    logic [6:0]         addr7;
    logic signed [31:0] opd;
    logic [31:0]        prod;
    logic               accept;

    dam_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_a),
        .wdata (mem_wd),
        .rdata (mem_rd)
    );

    dam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign pc_inc     = (pc_reg == AW'(MEM_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign recip_prod = 26'(mem_rd[12:0]) * 26'(RECIP100);
    assign hund       = 13'(opc_reg) * DEC_BASE;
    assign addr7      = 7'(w13_reg - hund);
    assign opd        = mem_rd;
    assign prod       = acc_reg * opd;
    assign res_load   = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        acc_next   = acc_reg;
        stat_next  = stat_reg;
        clr_next   = clr_reg;
        inv_next   = inv_reg;
        w13_next   = w13_reg;
        opc_next   = opc_reg;
        bad_next   = bad_reg;
        prt_next   = prt_reg;
        prtv_next  = prtv_reg;
        used_next  = used_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_a      = pc_reg;
        mem_wd     = acc_reg;
        div_req    = '{start: 1'b0, fast: 1'b0, dividend: acc_reg, divisor: SHR_DIV};

        case (state_reg)
            S_CLEAR:
            begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                mem_a  = clr_reg;
                mem_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    inv_next   = in_value;
                    prt_next   = 1'b0;
                    prtv_next  = '0;
                    used_next  = 1'b0;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_WRITE:
                        begin
                            if (32'(mem_addr) < MEM_DEPTH)
                            begin
                                mem_en = 1'b1;
                                mem_we = 1'b1;
                                mem_a  = AW'(mem_addr);
                                mem_wd = mem_word;
                            end
                        end
                        CMD_EXEC:
                        begin
                            if (stat_reg == ST_RUN)
                            begin
                                mem_en     = 1'b1;
                                mem_a      = pc_reg;
                                state_next = S_FETCH;
                            end
                        end
                        CMD_RESTART:
                        begin
                            pc_next   = '0;
                            stat_next = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                w13_next   = mem_rd[12:0];
                opc_next   = recip_prod[25:19];
                bad_next   = mem_rd[31] || (|mem_rd[30:13]);
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (bad_reg)
                begin
                    stat_next = ST_INVALID;
                end
                else
                begin
                    case (opc_reg)
                        OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_PRINT:
                        begin
                            mem_en     = 1'b1;
                            mem_a      = AW'(addr7);
                            state_next = S_OPER;
                        end
                        OP_STORE:
                        begin
                            mem_en  = 1'b1;
                            mem_we  = 1'b1;
                            mem_a   = AW'(addr7);
                            mem_wd  = acc_reg;
                            pc_next = pc_inc;
                        end
                        OP_READ:
                        begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_a     = AW'(addr7);
                            mem_wd    = inv_reg;
                            used_next = 1'b1;
                            pc_next   = pc_inc;
                        end
                        OP_NOP:
                        begin
                            pc_next = pc_inc;
                        end
                        OP_BR:
                        begin
                            pc_next = AW'(addr7);
                        end
                        OP_BRGT:
                        begin
                            pc_next = (acc_reg > 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_BRGE:
                        begin
                            pc_next = (acc_reg >= 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_BRLT:
                        begin
                            pc_next = (acc_reg < 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_BRLE:
                        begin
                            pc_next = (acc_reg <= 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_BRNE:
                        begin
                            pc_next = (acc_reg != 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_BREQ:
                        begin
                            pc_next = (acc_reg == 0) ? AW'(addr7) : pc_inc;
                        end
                        OP_SHL:
                        begin
                            div_req    = '{start: 1'b1, fast: 1'b1,
                                           dividend: acc_reg, divisor: SHL_MOD};
                            state_next = S_DIVW;
                        end
                        OP_SHR:
                        begin
                            div_req    = '{start: 1'b1, fast: 1'b1,
                                           dividend: acc_reg, divisor: SHR_DIV};
                            state_next = S_DIVW;
                        end
                        OP_HALT:
                        begin
                            stat_next = ST_HALT;
                        end
                        default:
                        begin
                            stat_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_OPER:
            begin
                state_next = S_DONE;
                pc_next    = pc_inc;
                case (opc_reg)
                    OP_LOAD:
                    begin
                        acc_next = opd;
                    end
                    OP_ADD:
                    begin
                        acc_next = acc_reg + opd;
                    end
                    OP_SUB:
                    begin
                        acc_next = acc_reg - opd;
                    end
                    OP_MUL:
                    begin
                        acc_next = prod;
                    end
                    OP_PRINT:
                    begin
                        prt_next  = 1'b1;
                        prtv_next = opd;
                    end
                    OP_DIV, OP_REM:
                    begin
                        if (opd == 0)
                        begin
                            stat_next = ST_DIVZERO;
                            pc_next   = pc_reg;
                        end
                        else
                        begin
                            pc_next    = pc_reg;
                            div_req    = '{start: 1'b1, fast: 1'b0,
                                           dividend: acc_reg, divisor: opd};
                            state_next = S_DIVW;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    pc_next    = pc_inc;
                    state_next = S_DONE;
                    case (opc_reg)
                        OP_DIV:
                        begin
                            acc_next = div_rsp.quo;
                        end
                        OP_REM:
                        begin
                            acc_next = div_rsp.rem;
                        end
                        OP_SHL:
                        begin
                            acc_next = {div_rsp.rem[28:0], 3'b000}
                                     + {div_rsp.rem[30:0], 1'b0};
                        end
                        default:
                        begin
                            acc_next = div_rsp.quo;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pc_reg        <= '0;
            acc_reg       <= '0;
            stat_reg      <= ST_RUN;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            stat_reg      <= stat_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inv_reg  <= inv_next;
        w13_reg  <= w13_next;
        opc_reg  <= opc_next;
        bad_reg  <= bad_next;
        prt_reg  <= prt_next;
        prtv_reg <= prtv_next;
        used_reg <= used_next;
        if (res_load)
        begin
            r_stat_reg <= stat_reg;
            r_prt_reg  <= prt_reg;
            r_prtv_reg <= prtv_reg;
            r_used_reg <= used_reg;
            r_acc_reg  <= acc_reg;
            r_pc_reg   <= pc_reg[6:0];
        end
    end

    assign res_valid  = res_valid_reg;
    assign run_status = r_stat_reg;
    assign out_valid  = r_prt_reg;
    assign out_value  = r_prtv_reg;
    assign in_used    = r_used_reg;
    assign acc_now    = r_acc_reg;
    assign pc_now     = r_pc_reg;

endmodule

@@ src/dam_checker.sv @@
// ----------------------------------------------------------------------------
// dam_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "decimal_accumulator_machine_step_macros.svh"

module dam_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input logic [1:0]         run_status,
    input logic               out_valid,
    input logic signed [31:0] out_value,
    input logic               in_used,
    input logic signed [31:0] acc_now
);
    import dam_pkg::*;

    `DAM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid)
    `DAM_ASSERT_NEXT(a_acc_hold, clk, rst_n, res_valid && res_stall, $stable(acc_now))
    `DAM_ASSERT_IMPLY(a_noprint_zero, clk, rst_n, res_valid && !out_valid, out_value == 0)
    `DAM_ASSERT_IMPLY(a_used_running, clk, rst_n, res_valid && in_used, !out_valid && run_status == ST_RUN)

endmodule

bind decimal_accumulator_machine_step dam_checker u_dam_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .run_status (run_status),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .in_used    (in_used),
    .acc_now    (acc_now)
);
